FILE: rtl/sfr_pkg.sv
package sfr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 4;
  localparam int WORD_W      = 64;
  localparam int JOB_BYTES   = 8;
  localparam int CNT_W       = $clog2(JOB_BYTES + 1);
  localparam int FILL_W      = $clog2(MAX_PATTERN + 1);
  localparam int CFG_IDX_W   = 4;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES     = 4'd0,
    CFG_PATTERN_LEN       = 4'd1,
    CFG_REPLACEMENT_BYTES = 4'd2,
    CFG_REPLACEMENT_LEN   = 4'd3
  } cfg_idx_e;

  // One run of result bytes caused by a single input item
  typedef struct packed {
    logic [JOB_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]                 cnt;
    logic                             last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: rtl/sfr_if.sv
interface sfr_in_if;
  import sfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              stream_end;
  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

interface sfr_out_if;
  import sfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              stream_done;
  modport source (output valid, output out_byte, output run_last, output stream_done,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input stream_done,
                output ready);
endinterface

interface sfr_cfg_if;
  import sfr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/sfr_front.sv
module sfr_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  sfr_in_if.sink                 in_i,
  sfr_cfg_if.sink                cfg_i,
  input  sfr_pkg::queue_status_t q_status_i,
  output logic                   push_o,
  output sfr_pkg::job_t          job_o
);
  import sfr_pkg::*;

  logic [WORD_W-1:0] pattern_q, pattern_d;
  logic [LEN_W-1:0]  plen_raw_q, plen_raw_d;
  logic [WORD_W-1:0] repl_q, repl_d;
  logic [LEN_W-1:0]  rlen_raw_q, rlen_raw_d;

  logic [BYTE_W-1:0] window_q [MAX_PATTERN];
  logic [BYTE_W-1:0] window_d [MAX_PATTERN];
  logic [FILL_W-1:0] fill_q, fill_d;

  logic [FILL_W-1:0] plen;
  logic [CNT_W-1:0]  rlen;
  logic [BYTE_W-1:0] win_app [MAX_PATTERN];
  logic [FILL_W-1:0] fill_inc;
  logic              full_win;
  logic              match;
  logic              accept;

  assign in_i.ready  = !q_status_i.full;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;

  always_comb begin
    if (plen_raw_q == '0) begin
      plen = FILL_W'(1);
    end else if (plen_raw_q > LEN_W'(MAX_PATTERN)) begin
      plen = FILL_W'(MAX_PATTERN);
    end else begin
      plen = FILL_W'(plen_raw_q);
    end
    if (rlen_raw_q > LEN_W'(JOB_BYTES)) begin
      rlen = CNT_W'(JOB_BYTES);
    end else begin
      rlen = CNT_W'(rlen_raw_q);
    end
  end

  // Window with the new byte placed at the fill position
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      win_app[k] = (FILL_W'(k) == fill_q) ? in_i.in_byte : window_q[k];
    end
    fill_inc = fill_q + FILL_W'(1);
    full_win = (fill_inc == plen);
    match    = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (FILL_W'(k) < plen && win_app[k] != pattern_q[k*BYTE_W +: BYTE_W]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    job_o.bytes = '0;
    job_o.cnt   = '0;
    job_o.last  = in_i.stream_end;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      job_o.bytes[k] = win_app[k];
    end
    window_d = win_app;
    fill_d   = fill_inc;
    if (full_win && match) begin
      for (int k = 0; k < JOB_BYTES; k++) begin
        job_o.bytes[k] = repl_q[k*BYTE_W +: BYTE_W];
      end
      job_o.cnt = rlen;
      fill_d    = '0;
    end else if (full_win) begin
      // emit the oldest byte, or the whole window at stream end
      job_o.cnt = in_i.stream_end ? CNT_W'(plen) : CNT_W'(1);
      for (int k = 0; k < MAX_PATTERN - 1; k++) begin
        window_d[k] = win_app[k+1];
      end
      fill_d = plen - FILL_W'(1);
    end else if (in_i.stream_end) begin
      job_o.cnt = CNT_W'(fill_inc);
    end
    if (in_i.stream_end) begin
      fill_d = '0;
    end
  end

  assign push_o = accept && (job_o.cnt != '0);

  always_comb begin
    pattern_d  = pattern_q;
    plen_raw_d = plen_raw_q;
    repl_d     = repl_q;
    rlen_raw_d = rlen_raw_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_PATTERN_BYTES:     pattern_d  = cfg_i.data;
        CFG_PATTERN_LEN:       plen_raw_d = cfg_i.data[LEN_W-1:0];
        CFG_REPLACEMENT_BYTES: repl_d     = cfg_i.data;
        CFG_REPLACEMENT_LEN:   rlen_raw_d = cfg_i.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q  <= '0;
      plen_raw_q <= LEN_W'(1);
      repl_q     <= '0;
      rlen_raw_q <= '0;
      fill_q     <= '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        window_q[k] <= '0;
      end
    end else begin
      pattern_q  <= pattern_d;
      plen_raw_q <= plen_raw_d;
      repl_q     <= repl_d;
      rlen_raw_q <= rlen_raw_d;
      if (accept) begin
        window_q <= window_d;
        fill_q   <= fill_d;
      end
      // new pattern length: drop the window
      if (cfg_i.valid && cfg_idx_e'(cfg_i.index) == CFG_PATTERN_LEN) begin
        fill_q <= '0;
      end
    end
  end

endmodule

FILE: rtl/sfr_queue.sv
module sfr_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  sfr_pkg::job_t          job_i,
  input  logic                   pop_i,
  output sfr_pkg::job_t          head_o,
  output sfr_pkg::queue_status_t status_o
);
  import sfr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_Q-1:0] count_q, count_d;

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == CNT_Q'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_Q'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_Q'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
    end
  end

endmodule

FILE: rtl/sfr_back.sv
module sfr_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sfr_pkg::job_t          head_i,
  input  sfr_pkg::queue_status_t q_status_i,
  output logic                   pop_o,
  sfr_out_if.source              out_o
);
  import sfr_pkg::*;

  localparam int IDX_W = $clog2(JOB_BYTES);

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              valid_q;
  logic [BYTE_W-1:0] byte_q;
  logic              run_last_q;
  logic              done_q;
  logic              load;
  logic              is_last;

  // Refill the output register when it is empty or being taken
  assign load    = !q_status_i.empty && (!valid_q || out_o.ready);
  assign is_last = (CNT_W'(idx_q) == head_i.cnt - CNT_W'(1));
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = is_last ? '0 : idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q     <= head_i.bytes[idx_q];
      run_last_q <= is_last;
      done_q     <= is_last && head_i.last;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.out_byte    = byte_q;
  assign out_o.run_last    = run_last_q;
  assign out_o.stream_done = done_q;

endmodule

FILE: rtl/stream_find_replace_core.sv
// Latency: an item's first result passes through the job queue and then the output register.
// Throughput: one input item per cycle while the job queue is not full and each item yields
// at most one result; the output side gives one result per cycle while the receiver is ready.
// A four-entry job queue between window logic and output serializer absorbs bursts.
// Reset (rst_ni low, asynchronous) empties window, queue and output register and
// restores pattern_len to one and the other configuration registers to zero.
module stream_find_replace_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfr_in_if.sink    in_i,
  sfr_cfg_if.sink   cfg_i,
  sfr_out_if.source out_o
);
  import sfr_pkg::*;

  job_t          job;
  job_t          head;
  logic          push;
  logic          pop;
  queue_status_t q_status;

  sfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_i      (cfg_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (job)
  );

  sfr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  sfr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

FILE: rtl/sfr_chk.sv
module sfr_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [sfr_pkg::BYTE_W-1:0] out_byte_i,
  input logic                      run_last_i,
  input logic                      stream_done_i
);
  import sfr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_byte_i) && $stable(run_last_i)
      && $stable(stream_done_i))
    else $error("stalled result changed");

  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && stream_done_i |-> run_last_i)
    else $error("stream end not on last result of its item");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result shown during reset");

endmodule

bind stream_find_replace_core sfr_chk u_sfr_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .run_last_i    (out_o.run_last),
  .stream_done_i (out_o.stream_done)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

import sfr_pkg::*;

typedef struct packed {
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              stream_done;
} text_result_t;

typedef struct packed {
  logic [WORD_W-1:0] pat;
  logic [LEN_W-1:0]  plen;
  logic [WORD_W-1:0] rep;
  logic [LEN_W-1:0]  rlen;
} fr_setting_t;

class find_replace_scoreboard;
  logic [WORD_W-1:0] pat_word;
  logic [LEN_W-1:0]  pat_len_reg;
  logic [WORD_W-1:0] rep_word;
  logic [LEN_W-1:0]  rep_len_reg;
  logic [BYTE_W-1:0] win[MAX_PATTERN];
  int unsigned       fill;
  text_result_t      out_bytes_q[$];
  int unsigned       errors;
  int unsigned       checked;
  int unsigned       hits;

  function new();
    pat_word    = '0;
    pat_len_reg = 4'd1;
    rep_word    = '0;
    rep_len_reg = '0;
    fill        = 0;
    errors      = 0;
    checked     = 0;
    hits        = 0;
  endfunction

  function void note_config(cfg_idx_e idx, logic [WORD_W-1:0] d);
    case (idx)
      CFG_PATTERN_BYTES:     pat_word = d;
      CFG_PATTERN_LEN: begin
        // a new pattern length drops whatever sits in the window
        pat_len_reg = d[LEN_W-1:0];
        fill        = 0;
      end
      CFG_REPLACEMENT_BYTES: rep_word = d;
      CFG_REPLACEMENT_LEN:   rep_len_reg = d[LEN_W-1:0];
      default: ;
    endcase
  endfunction

  function void note_input(logic [BYTE_W-1:0] b, logic fin);
    int unsigned  plen;
    int unsigned  rlen;
    int unsigned  k;
    int unsigned  first;
    bit           hit;
    text_result_t r;
    first = out_bytes_q.size();
    plen  = (pat_len_reg == 0) ? 1 :
            (pat_len_reg > MAX_PATTERN) ? MAX_PATTERN : pat_len_reg;
    rlen  = (rep_len_reg > JOB_BYTES) ? JOB_BYTES : rep_len_reg;
    r     = '0;
    win[fill] = b;
    fill++;
    if (fill >= plen) begin
      hit = 1'b1;
      for (k = 0; k < plen; k++)
        if (win[k] != pat_word[8*k +: 8]) hit = 1'b0;
      if (hit) begin
        for (k = 0; k < rlen; k++) begin
          r.out_byte = rep_word[8*k +: 8];
          out_bytes_q.push_back(r);
        end
        fill = 0;
        hits++;
      end else begin
        r.out_byte = win[0];
        out_bytes_q.push_back(r);
        for (k = 0; k < MAX_PATTERN - 1; k++) win[k] = win[k+1];
        fill--;
      end
    end
    if (fin) begin
      for (k = 0; k < fill; k++) begin
        r.out_byte = win[k];
        out_bytes_q.push_back(r);
      end
      fill = 0;
    end
    // tag the last byte of this item's run
    if (out_bytes_q.size() > first) begin
      out_bytes_q[out_bytes_q.size()-1].run_last    = 1'b1;
      out_bytes_q[out_bytes_q.size()-1].stream_done = fin;
    end
  endfunction

  function void check_result(logic [BYTE_W-1:0] b, logic rl, logic sd);
    text_result_t want;
    checked++;
    if (out_bytes_q.size() == 0) begin
      $display("%0t: unexpected output byte, expected none, actual %h run_last %b stream_done %b",
               $time, b, rl, sd);
      errors++;
      return;
    end
    want = out_bytes_q.pop_front();
    if (want.out_byte !== b) begin
      $display("%0t: out_byte mismatch, expected %h, actual %h", $time, want.out_byte, b);
      errors++;
    end
    if (want.run_last !== rl) begin
      $display("%0t: run_last mismatch, expected %b, actual %b", $time, want.run_last, rl);
      errors++;
    end
    if (want.stream_done !== sd) begin
      $display("%0t: stream_done mismatch, expected %b, actual %b",
               $time, want.stream_done, sd);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return out_bytes_q.size();
  endfunction
endclass

module tb_top;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int TOTAL_ITEMS  = 205;
  localparam int CALM_TAIL    = 40;

  logic clk_i;
  logic rst_ni;

  sfr_in_if  in_if ();
  sfr_cfg_if cfg_if ();
  sfr_out_if out_if ();

  stream_find_replace_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  find_replace_scoreboard sb = new();

  fr_setting_t cur;
  bit          idle_on;
  int unsigned stall_left;
  int unsigned quiet_cycles;
  int unsigned items_sent;
  int unsigned streams_ended;
  int unsigned settings_used;

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver: random stall bursts while idling is on
  always @(negedge clk_i) begin
    if (!idle_on) begin
      stall_left = 0;
      out_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready)
      sb.check_result(out_if.out_byte, out_if.run_last, out_if.stream_done);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (out_if.valid === 1'b1 && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_item(logic [BYTE_W-1:0] b, logic fin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.in_byte    <= b;
    in_if.stream_end <= fin;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(b, fin);
    items_sent++;
    if (fin) streams_ended++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input logic [BYTE_W-1:0] text[$], bit close_stream);
    int unsigned i;
    for (i = 0; i < text.size(); i++)
      send_item(text[i], close_stream && (i == text.size() - 1));
  endtask

  // hold until every expected byte is out and items without output have drained
  task automatic quiesce();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [WORD_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.note_config(idx, d);
    @(negedge clk_i);
  endtask

  task automatic apply_setting(fr_setting_t s, bit keep_window);
    quiesce();
    write_reg(CFG_PATTERN_BYTES, s.pat);
    if (keep_window)
      s.plen = cur.plen;
    else
      write_reg(CFG_PATTERN_LEN, {{(WORD_W-LEN_W){1'b0}}, s.plen});
    write_reg(CFG_REPLACEMENT_BYTES, s.rep);
    write_reg(CFG_REPLACEMENT_LEN, {{(WORD_W-LEN_W){1'b0}}, s.rlen});
    cfg_if.valid <= 1'b0;
    cur = s;
    settings_used++;
  endtask

  task automatic run_random_phase(int unsigned n_items);
    fr_setting_t       s;
    logic [BYTE_W-1:0] alpha[3];
    logic [BYTE_W-1:0] b;
    int unsigned       i;
    int unsigned       k;
    int unsigned       plen;
    int unsigned       bad;
    int unsigned       r;
    for (k = 0; k < 3; k++) alpha[k] = BYTE_W'($urandom_range(0, 255));
    s.pat = {$urandom, $urandom};
    // small alphabet gives partial and overlapping matches
    if ($urandom_range(0, 2) != 0)
      for (k = 0; k < 8; k++) s.pat[8*k +: 8] = alpha[$urandom_range(0, 2)];
    s.plen = ($urandom_range(0, 5) == 0) ? LEN_W'($urandom_range(0, 15))
                                         : LEN_W'($urandom_range(1, 8));
    s.rep  = {$urandom, $urandom};
    s.rlen = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(0, 15))
                                         : LEN_W'($urandom_range(0, 8));
    apply_setting(s, $urandom_range(0, 3) == 0);
    plen = (cur.plen == 0) ? 1 : (cur.plen > MAX_PATTERN) ? MAX_PATTERN : cur.plen;
    i = 0;
    while (i < n_items) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        bad = ($urandom_range(0, 5) == 0) ? $urandom_range(0, plen - 1) : plen;
        for (k = 0; k < plen; k++) begin
          b = (k == bad) ? BYTE_W'($urandom_range(0, 255)) : cur.pat[8*k +: 8];
          send_item(b, (k == plen - 1) && ($urandom_range(0, 9) == 0));
          i++;
        end
      end else begin
        b = (r < 8) ? alpha[$urandom_range(0, 2)] : BYTE_W'($urandom_range(0, 255));
        send_item(b, $urandom_range(0, 11) == 0);
        i++;
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] text[$];
    in_if.valid      = 1'b0;
    in_if.in_byte    = '0;
    in_if.stream_end = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_PATTERN_BYTES;
    cfg_if.data      = '0;
    out_if.ready     = 1'b0;
    rst_ni           = 1'b0;
    idle_on          = 1'b1;
    stall_left       = 0;
    quiet_cycles     = 0;
    items_sent       = 0;
    streams_ended    = 0;
    settings_used    = 0;
    cur              = '{pat: '0, plen: 4'd1, rep: '0, rlen: '0};
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // three-byte pattern with junk in unused high bytes, shifted match, flush
    apply_setting('{pat: 64'h5A5A5A5A_5AA500FF, plen: 4'd3,
                    rep: 64'hC3C3C3C3_C3C35958, rlen: 4'd2}, 1'b0);
    text = '{8'h00, 8'hFF, 8'h00, 8'hA5, 8'hFF, 8'hFF, 8'h00, 8'hA5, 8'h12, 8'hFF};
    send_text(text, 1'b1);

    // length zero acts as one, replacement length saturates to eight
    apply_setting('{pat: 64'hFFFFFFFF_FFFFFF7E, plen: 4'd0,
                    rep: 64'h01234567_89ABCDEF, rlen: 4'd15}, 1'b0);
    text = '{8'h7E, 8'h01, 8'h7E};
    send_text(text, 1'b1);

    // pattern length saturates to eight, matches deleted
    apply_setting('{pat: 64'h08070605_04030201, plen: 4'd15,
                    rep: 64'hFFFFFFFF_FFFFFFFF, rlen: 4'd0}, 1'b0);
    text = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h80, 8'h01};
    send_text(text, 1'b1);

    // stream end that emits nothing, then a fresh stream
    apply_setting('{pat: 64'h0, plen: 4'd1, rep: 64'hAAAAAAAA_AAAAAAAA, rlen: 4'd0}, 1'b0);
    text = '{8'h00};
    send_text(text, 1'b1);
    text = '{8'hFF};
    send_text(text, 1'b1);

    while (items_sent < TOTAL_ITEMS) begin
      idle_on = (items_sent + CALM_TAIL < TOTAL_ITEMS) && ($urandom_range(0, 3) != 0);
      run_random_phase($urandom_range(12, 30));
    end
    quiesce();

    $display("covered %0d input items over %0d register settings, %0d stream ends",
             items_sent, settings_used, streams_ended);
    $display("checked %0d output bytes, %0d pattern hits", sb.checked, sb.hits);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/sfr_pkg.sv
rtl/sfr_if.sv
rtl/sfr_front.sv
rtl/sfr_queue.sv
rtl/sfr_back.sv
rtl/stream_find_replace_core.sv
rtl/sfr_chk.sv
sim/tb_top.sv
